FILE: rtl/bql_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bql_pkg: shared types and constants
// Coefficient and control types, channel count and saturation helpers for the
// six channel biquad low-pass filter.
// ----------------------------------------------------------------------------
package bql_pkg;

	localparam int NumChannels = 6;

	localparam logic signed [17:0] FwdOuterDefault  = 18'sd2893;
	localparam logic signed [17:0] FwdMiddleDefault = 18'sd5786;
	localparam logic signed [17:0] BackOneDefault   = 18'sd86780;
	localparam logic signed [17:0] BackTwoDefault   = -18'sd32814;

	localparam logic signed [23:0] HistMax = 24'sh7FFFFF;
	localparam logic signed [23:0] HistMin = -24'sh800000;
	localparam logic signed [15:0] OutMax  = 16'sh7FFF;
	localparam logic signed [15:0] OutMin  = -16'sh8000;

	localparam logic [1:0] WarmDone = 2'd2;

	typedef enum logic [1:0] {
		RegFwdOuter  = 2'd0,
		RegFwdMiddle = 2'd1,
		RegBackOne   = 2'd2,
		RegBackTwo   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [17:0] fwd_outer;
		logic signed [17:0] fwd_middle;
		logic signed [17:0] back_one;
		logic signed [17:0] back_two;
	} coef_t;

	typedef struct packed {
		logic       accept;
		logic       adv;
		logic [1:0] warm;
		logic       run;
	} lane_ctl_t;

	function automatic logic signed [23:0] sat_hist(input logic signed [28:0] v);
		logic signed [23:0] r;
		if (v > 29'sd8388607) begin
			r = HistMax;
		end else if (v < -29'sd8388608) begin
			r = HistMin;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat_out(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v > 17'sd32767) begin
			r = OutMax;
		end else if (v < -17'sd32768) begin
			r = OutMin;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/bql_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bql_if: channel interfaces
// Sample vector channel, filtered result channel and coefficient write
// channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface bql_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_0;
	logic signed [15:0] sample_1;
	logic signed [15:0] sample_2;
	logic signed [15:0] sample_3;
	logic signed [15:0] sample_4;
	logic signed [15:0] sample_5;

	modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		sample_5, input ready);
	modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		sample_5, output ready);
endinterface

interface bql_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] filtered_0;
	logic signed [15:0] filtered_1;
	logic signed [15:0] filtered_2;
	logic signed [15:0] filtered_3;
	logic signed [15:0] filtered_4;
	logic signed [15:0] filtered_5;
	logic               settled;

	modport source (output valid, filtered_0, filtered_1, filtered_2, filtered_3,
		filtered_4, filtered_5, settled, input ready);
	modport sink (input valid, filtered_0, filtered_1, filtered_2, filtered_3,
		filtered_4, filtered_5, settled, output ready);
endinterface

interface bql_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [17:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/bql_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bql_lane: one filter channel
// Input history, feed-forward stage and the recursive feedback stage of a
// direct-form-I biquad with 8 fraction bits of output history.
// ----------------------------------------------------------------------------
module bql_lane import bql_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lane_ctl_t          ctl,
	input  wire coef_t              coef,
	input  wire logic signed [15:0] sample,
	output logic signed [23:0]      y_s2
);

	logic signed [15:0] x1_q;
	logic signed [15:0] x2_q;
	logic signed [23:0] y1_q;
	logic signed [23:0] y2_q;
	logic signed [35:0] fwd_s1;

	logic signed [16:0] xsum;
	logic signed [34:0] prod_a;
	logic signed [33:0] prod_b;
	logic signed [35:0] fwd;
	logic signed [41:0] prod_c;
	logic signed [41:0] prod_d;
	logic signed [44:0] acc;
	logic signed [23:0] y_new;

	always_comb begin
		xsum   = 17'(sample) + 17'(x2_q);
		prod_a = 35'(coef.fwd_outer) * 35'(xsum);
		prod_b = 34'(coef.fwd_middle) * 34'(x1_q);
		fwd    = 36'(prod_a) + 36'(prod_b);
	end

	always_comb begin
		prod_c = 42'(coef.back_one) * 42'(y1_q);
		prod_d = 42'(coef.back_two) * 42'(y2_q);
		acc    = (45'(fwd_s1) <<< 8) + 45'(prod_c) + 45'(prod_d) + 45'sd32768;
		y_new  = sat_hist(29'(acc >>> 16));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
		end else if (ctl.accept) begin
			case (ctl.warm)
				2'd0: begin
					x2_q <= sample;
				end
				2'd1: begin
					x1_q <= sample;
				end
				default: begin
					x2_q <= x1_q;
					x1_q <= sample;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y1_q <= '0;
			y2_q <= '0;
		end else if (ctl.run) begin
			y2_q <= y1_q;
			y1_q <= y_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			fwd_s1 <= fwd;
			y_s2   <= y_new;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bql_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bql_out: result merge and output register
// Rounds and saturates every lane's history value, zeroes the vector during
// warm-up and holds the combined result until the receiver takes it.
// ----------------------------------------------------------------------------
module bql_out import bql_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic signed [23:0] y_s2 [NumChannels],
	input  wire logic               valid_s2,
	input  wire logic               settled_s2,
	output logic                    adv,
	bql_result_if.source            res
);

	logic               valid_q;
	logic               settled_q;
	logic signed [15:0] filt_q [NumChannels];
	logic signed [24:0] rnd    [NumChannels];
	logic signed [15:0] filt   [NumChannels];

	assign adv = !valid_q || res.ready;

	always_comb begin
		for (int k = 0; k < NumChannels; k++) begin
			rnd[k]  = 25'(y_s2[k]) + 25'sd128;
			filt[k] = settled_s2 ? sat_out(17'(rnd[k] >>> 8)) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			filt_q    <= filt;
			settled_q <= settled_s2;
		end
	end

	assign res.valid      = valid_q;
	assign res.settled    = settled_q;
	assign res.filtered_0 = filt_q[0];
	assign res.filtered_1 = filt_q[1];
	assign res.filtered_2 = filt_q[2];
	assign res.filtered_3 = filt_q[3];
	assign res.filtered_4 = filt_q[4];
	assign res.filtered_5 = filt_q[5];

endmodule
`default_nettype wire

FILE: rtl/six_channel_biquad_lowpass.sv
`default_nettype none
// ----------------------------------------------------------------------------
// six_channel_biquad_lowpass: six channel Butterworth biquad low-pass filter
// Each transaction on the samples channel carries one six-axis force/torque
// vector; each transaction on the results channel returns the six filtered
// channels and a settled flag, one result per sample vector, in order.
// Six identical lanes filter the channels side by side in a three stage
// pipeline: feed-forward products, the recursive feedback sum, then the
// rounding, saturation and output register. Each accepted vector moves
// through valid_s1, valid_s2 and the output register before results.valid
// rises, and one vector is taken every cycle unless the receiver stalls.
// The cfg channel writes the four Q2.16 coefficients by index and is always
// ready; the user must write while the filter is idle, which is not enforced.
// The first two vectors after reset only load the input history and return
// zeros with settled low. Reset restores the default coefficients and clears
// all filter history and the warm-up count.
// When the receiver stalls, the whole pipeline holds and samples.ready drops
// until the held result is taken.
// ----------------------------------------------------------------------------
module six_channel_biquad_lowpass import bql_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bql_sample_if.sink   samples,
	bql_result_if.source results,
	bql_cfg_if.sink      cfg
);

	coef_t              coef_q;
	logic [1:0]         warm_q;
	logic               valid_s1;
	logic               settled_s1;
	logic               valid_s2;
	logic               settled_s2;
	logic               adv;
	logic               accept;
	lane_ctl_t          ctl;
	logic signed [15:0] x    [NumChannels];
	logic signed [23:0] y_s2 [NumChannels];

	assign cfg.ready     = 1'b1;
	assign samples.ready = adv;
	assign accept        = samples.valid && adv;

	assign x[0] = samples.sample_0;
	assign x[1] = samples.sample_1;
	assign x[2] = samples.sample_2;
	assign x[3] = samples.sample_3;
	assign x[4] = samples.sample_4;
	assign x[5] = samples.sample_5;

	always_comb begin
		ctl.accept = accept;
		ctl.adv    = adv;
		ctl.warm   = warm_q;
		ctl.run    = adv && valid_s1 && settled_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.fwd_outer  <= FwdOuterDefault;
			coef_q.fwd_middle <= FwdMiddleDefault;
			coef_q.back_one   <= BackOneDefault;
			coef_q.back_two   <= BackTwoDefault;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				RegFwdOuter:  coef_q.fwd_outer  <= cfg.data;
				RegFwdMiddle: coef_q.fwd_middle <= cfg.data;
				RegBackOne:   coef_q.back_one   <= cfg.data;
				RegBackTwo:   coef_q.back_two   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (accept && (warm_q != WarmDone)) begin
			warm_q <= warm_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			settled_s1 <= 1'b0;
			valid_s2   <= 1'b0;
			settled_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1   <= accept;
			settled_s1 <= (warm_q == WarmDone);
			valid_s2   <= valid_s1;
			settled_s2 <= settled_s1;
		end
	end

	for (genvar k = 0; k < NumChannels; k++) begin : g_lane
		bql_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.coef   (coef_q),
			.sample (x[k]),
			.y_s2   (y_s2[k])
		);
	end

	bql_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.y_s2       (y_s2),
		.valid_s2   (valid_s2),
		.settled_s2 (settled_s2),
		.adv        (adv),
		.res        (results)
	);

`ifndef ASSERT_OFF
	a_settled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && results.settled)
		|=> (!results.valid || results.settled))
		else $error("settled flag fell after warm-up");

	a_warmup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.settled)
		|-> (results.filtered_0 == '0 && results.filtered_1 == '0 &&
			results.filtered_2 == '0 && results.filtered_3 == '0 &&
			results.filtered_4 == '0 && results.filtered_5 == '0))
		else $error("nonzero output during warm-up");

	a_warm_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == WarmDone) |=> (warm_q == WarmDone))
		else $error("warm-up count left its final value");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_six_channel_biquad_lowpass.sv
// ----------------------------------------------------------------------------
// tb_six_channel_biquad_lowpass: regression for the six channel biquad filter
// Sample vectors are sent through the samples channel while the results
// channel is drained with random stalls. Every sample transaction is run
// through a fixed-point model of the six Butterworth lanes, and each result
// transaction is compared field by field with the oldest prediction.
// Coefficients are rewritten between phases, once the filter is idle.
// ----------------------------------------------------------------------------
module tb_six_channel_biquad_lowpass;
	import bql_pkg::*;

	typedef logic [NumChannels-1:0][15:0] vec_t;

	typedef struct packed {
		vec_t filtered;
		logic settled;
	} result_t;

	localparam int CycleLimit = 400000;
	localparam coef_t CoefDefaults = '{
		fwd_outer: FwdOuterDefault,
		fwd_middle: FwdMiddleDefault,
		back_one: BackOneDefault,
		back_two: BackTwoDefault
	};

	logic clk = 1'b0;
	logic arst_n;

	bql_sample_if samples_if();
	bql_result_if results_if();
	bql_cfg_if    cfg_if();

	six_channel_biquad_lowpass u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	coef_t   coefs;
	longint  in_one [NumChannels];
	longint  in_two [NumChannels];
	longint  out_one [NumChannels];
	longint  out_two [NumChannels];
	int      warm_count;
	result_t filtered_expected [$];
	int      fail_count;
	int      cycle_count;
	bit      gaps_on;
	vec_t    walk_level;
	result_t want;
	vec_t    seen;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		results_if.ready = gaps_on ? ($urandom_range(99) >= 11) : 1'b1;
	end

	// Fixed-point lanes: Q.24 sum, Q.8 history, integer output.
	task automatic predict_filtered(input vec_t x);
		result_t r;
		longint  xs;
		longint  fwd;
		longint  acc;
		longint  y;
		longint  o;
		for (int k = 0; k < NumChannels; k++) begin
			xs = longint'($signed(x[k]));
			o = 0;
			if (warm_count == 0) begin
				in_two[k] = xs;
			end else if (warm_count == 1) begin
				in_one[k] = xs;
			end else begin
				fwd = longint'($signed(coefs.fwd_outer)) * (xs + in_two[k])
					+ longint'($signed(coefs.fwd_middle)) * in_one[k];
				acc = fwd * 256
					+ longint'($signed(coefs.back_one)) * out_one[k]
					+ longint'($signed(coefs.back_two)) * out_two[k];
				y = (acc + 32768) >>> 16;
				if (y > 8388607) begin
					y = 8388607;
				end else if (y < -8388608) begin
					y = -8388608;
				end
				out_two[k] = out_one[k];
				out_one[k] = y;
				in_two[k] = in_one[k];
				in_one[k] = xs;
				o = (y + 128) >>> 8;
				if (o > 32767) begin
					o = 32767;
				end else if (o < -32768) begin
					o = -32768;
				end
			end
			r.filtered[k] = 16'(o);
		end
		r.settled = (warm_count >= 2);
		if (warm_count < 2) begin
			warm_count++;
		end
		filtered_expected = {filtered_expected, r};
	endtask

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			if (filtered_expected.size() == 0) begin
				$error("result transaction with nothing expected, settled %0b",
					results_if.settled);
				fail_count++;
			end else begin
				want = filtered_expected.pop_front();
				seen = {results_if.filtered_5, results_if.filtered_4, results_if.filtered_3,
					results_if.filtered_2, results_if.filtered_1, results_if.filtered_0};
				for (int k = 0; k < NumChannels; k++) begin
					if (seen[k] !== want.filtered[k]) begin
						$error("filtered_%0d expected %0d actual %0d", k,
							$signed(want.filtered[k]), $signed(seen[k]));
						fail_count++;
					end
				end
				if (results_if.settled !== want.settled) begin
					$error("settled expected %0b actual %0b", want.settled, results_if.settled);
					fail_count++;
				end
			end
		end
	end

	task automatic send_vector(input vec_t v);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 11) begin
			samples_if.valid = 1'b0;
			@(negedge clk);
		end
		samples_if.valid = 1'b1;
		samples_if.sample_0 = v[0];
		samples_if.sample_1 = v[1];
		samples_if.sample_2 = v[2];
		samples_if.sample_3 = v[3];
		samples_if.sample_4 = v[4];
		samples_if.sample_5 = v[5];
		do @(posedge clk); while (!samples_if.ready);
		predict_filtered(v);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		samples_if.valid = 1'b0;
		while (filtered_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_coef(input cfg_reg_t idx, input logic [17:0] d);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = d;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			RegFwdOuter: begin
				coefs.fwd_outer = d;
			end
			RegFwdMiddle: begin
				coefs.fwd_middle = d;
			end
			RegBackOne: begin
				coefs.back_one = d;
			end
			RegBackTwo: begin
				coefs.back_two = d;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic write_coef_set(input coef_t c);
		wait_drained();
		write_coef(RegFwdOuter, c.fwd_outer);
		write_coef(RegFwdMiddle, c.fwd_middle);
		write_coef(RegBackOne, c.back_one);
		write_coef(RegBackTwo, c.back_two);
	endtask

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(3))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic vec_t random_vector();
		vec_t v;
		int   pick;
		int   lvl;
		logic [15:0] same;
		pick = $urandom_range(99);
		same = 16'($urandom());
		for (int k = 0; k < NumChannels; k++) begin
			if (pick < 35) begin
				lvl = int'($signed(walk_level[k])) + int'($urandom_range(4095)) - 2048;
				if (lvl > 32767) begin
					lvl = 32767;
				end else if (lvl < -32768) begin
					lvl = -32768;
				end
				walk_level[k] = 16'(lvl);
				v[k] = walk_level[k];
			end else if (pick < 60) begin
				v[k] = 16'($urandom());
			end else if (pick < 75) begin
				v[k] = 16'(int'($urandom_range(600)) - 300);
			end else if (pick < 88) begin
				v[k] = pick_extreme();
			end else begin
				v[k] = same;
			end
		end
		return v;
	endfunction

	function automatic logic [17:0] near_default(input logic signed [17:0] base);
		return 18'(int'(base) + int'($urandom_range(4000)) - 2000);
	endfunction

	function automatic logic [17:0] coef_extreme();
		case ($urandom_range(2))
			0: return 18'h1FFFF;
			1: return 18'h20000;
			default: return 18'h00000;
		endcase
	endfunction

	function automatic coef_t random_coefs(input int kind);
		coef_t c;
		case (kind)
			0: begin
				c = coef_t'(72'({$urandom(), $urandom(), $urandom()}));
			end
			1: begin
				c.fwd_outer = near_default(FwdOuterDefault);
				c.fwd_middle = near_default(FwdMiddleDefault);
				c.back_one = near_default(BackOneDefault);
				c.back_two = near_default(BackTwoDefault);
			end
			default: begin
				c.fwd_outer = coef_extreme();
				c.fwd_middle = coef_extreme();
				c.back_one = coef_extreme();
				c.back_two = coef_extreme();
			end
		endcase
		return c;
	endfunction

	// The first two vectors only load the input history.
	task automatic test_warmup();
		send_vector({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
		send_vector({16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h5A5A});
		send_vector({16'h7FFF, 16'h8000, 16'hA5A5, 16'h0000, 16'hFFFF, 16'h0001});
	endtask

	task automatic test_full_scale();
		repeat (6) send_vector({NumChannels{16'h7FFF}});
		repeat (6) send_vector({NumChannels{16'h8000}});
		for (int i = 0; i < 4; i++) begin
			send_vector((i % 2) ? {NumChannels{16'h8000}} : {NumChannels{16'h7FFF}});
		end
	endtask

	task automatic test_coef_extremes();
		write_coef_set('{fwd_outer: 18'h1FFFF, fwd_middle: 18'h1FFFF,
			back_one: 18'h1FFFF, back_two: 18'h20000});
		send_vector({NumChannels{16'h7FFF}});
		send_vector({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
		send_vector({NumChannels{16'h8000}});
		write_coef_set('{fwd_outer: 18'h20000, fwd_middle: 18'h20000,
			back_one: 18'h20000, back_two: 18'h1FFFF});
		send_vector({NumChannels{16'h7FFF}});
		send_vector({NumChannels{16'h8000}});
		send_vector({NumChannels{16'h0000}});
	endtask

	task automatic test_random_defaults();
		write_coef_set(CoefDefaults);
		repeat (350) send_vector(random_vector());
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		repeat (250) send_vector(random_vector());
		gaps_on = 1'b1;
	endtask

	task automatic test_random_coefs();
		for (int s = 0; s < 8; s++) begin
			write_coef_set(random_coefs(s % 3));
			repeat (90) send_vector(random_vector());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		gaps_on = 1'b1;
		fail_count = 0;
		walk_level = '0;
		coefs = CoefDefaults;
		warm_count = 0;
		for (int k = 0; k < NumChannels; k++) begin
			in_one[k] = 0;
			in_two[k] = 0;
			out_one[k] = 0;
			out_two[k] = 0;
		end
		samples_if.valid = 1'b0;
		samples_if.sample_0 = '0;
		samples_if.sample_1 = '0;
		samples_if.sample_2 = '0;
		samples_if.sample_3 = '0;
		samples_if.sample_4 = '0;
		samples_if.sample_5 = '0;
		results_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = RegFwdOuter;
		cfg_if.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_warmup();
		test_full_scale();
		test_coef_extremes();
		test_random_defaults();
		test_back_to_back();
		test_random_coefs();

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("six_channel_biquad_lowpass regression: pass");
		end else begin
			$display("six_channel_biquad_lowpass regression: fail");
		end
		$finish;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("run did not finish within %0d cycles", CycleLimit);
		$display("six_channel_biquad_lowpass regression: fail");
		$finish;
	end

endmodule
